@@ sv/hrs_pkg.sv @@
// Package: types, constants, event and sequence tables for the haptic ramp sequencer.
package hrs_pkg;

   localparam int PadsDefault      = 2;
   localparam int EventsDefault    = 16;
   localparam int SequencesDefault = 5;
   localparam int RomEvents        = 16;
   localparam int RomSequences     = 5;
   localparam logic [16:0] ElapsedMax = 17'h1FFFF;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef struct packed {
      logic [15:0] wait_ms;
      logic        mtype;
      logic [15:0] gate_ms;
      logic [15:0] level;
   } event_type;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] last;
   } bound_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_WALK,
      ST_RAMP_LO,
      ST_DIV_LO,
      ST_RAMP_HI,
      ST_DIV_HI,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic start_seq;
      logic add;
      logic fire;
      logic ramp_setup;
      logic ramp_unit;
      logic div_step;
      logic lvl_store;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_start;
      logic pad_ok;
      logic seq_ok;
      logic active;
      logic due;
      logic div_needed;
      logic div_done;
   } stat_type;

   function automatic event_type event_rom(input logic [7:0] idx);
      event_type e;
      case (idx)
         8'd0:    e = '{16'd0,    1'b0, 16'd500,  16'd65535};
         8'd1:    e = '{16'd1000, 1'b0, 16'd1000, 16'd0};
         8'd2:    e = '{16'd0,    1'b1, 16'd250,  16'd65535};
         8'd3:    e = '{16'd250,  1'b1, 16'd750,  16'd0};
         8'd4:    e = '{16'd0,    1'b0, 16'd500,  16'd65535};
         8'd5:    e = '{16'd500,  1'b0, 16'd500,  16'd6554};
         8'd6:    e = '{16'd500,  1'b0, 16'd500,  16'd65535};
         8'd7:    e = '{16'd500,  1'b0, 16'd1000, 16'd0};
         8'd8:    e = '{16'd0,    1'b1, 16'd250,  16'd65535};
         8'd9:    e = '{16'd250,  1'b1, 16'd250,  16'd49151};
         8'd10:   e = '{16'd0,    1'b0, 16'd250,  16'd65535};
         8'd11:   e = '{16'd250,  1'b0, 16'd750,  16'd0};
         8'd12:   e = '{16'd500,  1'b1, 16'd500,  16'd0};
         8'd13:   e = '{16'd0,    1'b1, 16'd100,  16'd32768};
         8'd14:   e = '{16'd100,  1'b1, 16'd100,  16'd13107};
         8'd15:   e = '{16'd100,  1'b1, 16'd100,  16'd0};
         default: e = '0;
      endcase
      return e;
   endfunction

   function automatic bound_type sequence_bounds(input logic [2:0] sq);
      bound_type b;
      case (sq)
         3'd0:    b = '{8'd0,  8'd1};
         3'd1:    b = '{8'd2,  8'd3};
         3'd2:    b = '{8'd4,  8'd7};
         3'd3:    b = '{8'd8,  8'd12};
         3'd4:    b = '{8'd13, 8'd15};
         default: b = '{8'd0,  8'd1};
      endcase
      return b;
   endfunction

endpackage

@@ sv/hrs_ctrl.sv @@
// Controller state machine: sequences the tick and start work.
module hrs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  hrs_pkg::stat_type  stat,
   output hrs_pkg::cmd_type   cmd
);

   hrs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrs_pkg::ST_IDLE:
            if (req_valid) state_in = hrs_pkg::ST_ADD;
         hrs_pkg::ST_ADD: begin
            if (!stat.pad_ok || stat.is_start) state_in = hrs_pkg::ST_IDLE;
            else if (!stat.active) state_in = hrs_pkg::ST_OUT;
            else state_in = hrs_pkg::ST_WALK;
         end
         hrs_pkg::ST_WALK:
            if (!stat.due) state_in = hrs_pkg::ST_RAMP_LO;
         hrs_pkg::ST_RAMP_LO: begin
            state_in = stat.div_needed ? hrs_pkg::ST_DIV_LO : hrs_pkg::ST_RAMP_HI;
         end
         hrs_pkg::ST_DIV_LO:
            if (stat.div_done) state_in = hrs_pkg::ST_RAMP_HI;
         hrs_pkg::ST_RAMP_HI: begin
            state_in = stat.div_needed ? hrs_pkg::ST_DIV_HI : hrs_pkg::ST_OUT;
         end
         hrs_pkg::ST_DIV_HI:
            if (stat.div_done) state_in = hrs_pkg::ST_OUT;
         hrs_pkg::ST_OUT:
            if (!rsp_valid || !rsp_stall) state_in = hrs_pkg::ST_IDLE;
         default: state_in = hrs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != hrs_pkg::ST_IDLE);
      case (state_ff)
         hrs_pkg::ST_IDLE: cmd.load = req_valid;
         hrs_pkg::ST_ADD: begin
            cmd.start_seq = stat.pad_ok && stat.is_start && stat.seq_ok;
            cmd.add = stat.pad_ok && !stat.is_start && stat.active;
         end
         hrs_pkg::ST_WALK: cmd.fire = stat.due;
         hrs_pkg::ST_RAMP_LO: begin
            cmd.ramp_setup = 1'b1;
            cmd.ramp_unit  = 1'b0;
         end
         hrs_pkg::ST_DIV_LO: begin
            cmd.div_step  = 1'b1;
            cmd.ramp_unit = 1'b0;
            cmd.lvl_store = stat.div_done;
         end
         hrs_pkg::ST_RAMP_HI: begin
            cmd.ramp_setup = 1'b1;
            cmd.ramp_unit  = 1'b1;
         end
         hrs_pkg::ST_DIV_HI: begin
            cmd.div_step  = 1'b1;
            cmd.ramp_unit = 1'b1;
            cmd.lvl_store = stat.div_done;
         end
         hrs_pkg::ST_OUT: cmd.emit = !rsp_valid || !rsp_stall;
         default: cmd = '0;
      endcase
   end

endmodule

@@ sv/hrs_dp.sv @@
// Datapath: pad and motor state, event walk, ramp interpolation with serial divider.
module hrs_dp #(
   parameter int PADS      = hrs_pkg::PadsDefault,
   parameter int EVENTS    = hrs_pkg::EventsDefault,
   parameter int SEQUENCES = hrs_pkg::SequencesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_opcode,
   input  logic              req_pad,
   input  logic [15:0]       req_delta_ms,
   input  logic [2:0]        req_sequence_req,
   input  hrs_pkg::cmd_type  cmd,
   output hrs_pkg::stat_type stat,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_out_pad,
   output logic [15:0]       rsp_low_level,
   output logic [15:0]       rsp_high_level
);

   localparam int Units = 2 * PADS;

   logic        op_ff;
   logic        pad_ff;
   logic [15:0] delta_ff;
   logic [2:0]  sreq_ff;

   logic        active_ff [PADS];
   logic [2:0]  seqn_ff   [PADS];
   logic [7:0]  idx_ff    [PADS];
   logic [16:0] elap_ff   [PADS];

   logic [15:0] rtime_ff  [Units];
   logic [15:0] rgate_ff  [Units];
   logic [15:0] rstart_ff [Units];
   logic [15:0] rtarg_ff  [Units];

   logic [15:0] lo_ff, hi_ff;
   logic        valid_ff;

   // serial divider
   logic [31:0] num_ff;
   logic [15:0] den_ff;
   logic [16:0] rem_ff;
   logic [31:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        down_ff;
   logic [15:0] base_ff;
   logic        q_bit;
   logic [15:0] lvl_res;

   logic        pad_ok;
   logic [2:0]  sq;
   hrs_pkg::bound_type bnd;
   logic [8:0]  count;
   logic [8:0]  eidx;
   hrs_pkg::event_type ev;
   logic [1:0]  uf;
   logic [1:0]  ur;
   logic [16:0] sum;
   logic [17:0] esum;
   logic [16:0] rem_sh;

   assign pad_ok = (32'(pad_ff) < PADS);
   assign sq     = (32'(seqn_ff[pad_ff]) >= SEQUENCES) ? 3'd0 : seqn_ff[pad_ff];
   assign bnd    = hrs_pkg::sequence_bounds(sq);
   assign count  = 9'(bnd.last) - 9'(bnd.first) + 9'd1;
   assign eidx   = 9'(bnd.first) + 9'(idx_ff[pad_ff]);
   assign ev     = hrs_pkg::event_rom(eidx[7:0]);
   assign uf     = {pad_ff, ev.mtype};
   assign ur     = {pad_ff, cmd.ramp_unit};
   assign sum    = 17'(rtime_ff[ur]) + 17'(delta_ff);
   assign esum   = 18'(elap_ff[pad_ff]) + 18'(delta_ff);
   assign rem_sh = {rem_ff[15:0], num_ff[31]};
   // final quotient bit comes from the last divide step
   assign q_bit  = (rem_sh >= 17'(den_ff));
   assign lvl_res = down_ff ? base_ff - {quo_ff[14:0], q_bit}
                            : base_ff + {quo_ff[14:0], q_bit};

   always_comb begin
      stat.is_start   = (op_ff == hrs_pkg::OP_START);
      stat.pad_ok     = pad_ok;
      stat.seq_ok     = (32'(sreq_ff) < SEQUENCES);
      stat.active     = active_ff[pad_ff];
      stat.due        = (9'(idx_ff[pad_ff]) < count) && (32'(eidx) < EVENTS)
                        && (elap_ff[pad_ff] >= 17'(ev.wait_ms));
      stat.div_needed = (sum < 17'(rgate_ff[ur]));
      stat.div_done   = (cnt_ff == 5'd31);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         pad_ff   <= req_pad;
         delta_ff <= req_delta_ms;
         sreq_ff  <= req_sequence_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PADS; p++) begin
            active_ff[p] <= 1'b0;
            seqn_ff[p]   <= '0;
            idx_ff[p]    <= '0;
            elap_ff[p]   <= '0;
         end
         for (int u = 0; u < Units; u++) begin
            rtime_ff[u]  <= '0;
            rgate_ff[u]  <= '0;
            rstart_ff[u] <= '0;
            rtarg_ff[u]  <= '0;
         end
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.start_seq) begin
            active_ff[pad_ff] <= 1'b1;
            seqn_ff[pad_ff]   <= sreq_ff;
            idx_ff[pad_ff]    <= '0;
            elap_ff[pad_ff]   <= '0;
         end
         if (cmd.add)
            elap_ff[pad_ff] <= esum[17] ? hrs_pkg::ElapsedMax : esum[16:0];
         // idle pads report zero levels
         if (cmd.load) begin
            lo_ff <= '0;
            hi_ff <= '0;
         end
         if (cmd.fire) begin
            elap_ff[pad_ff] <= elap_ff[pad_ff] - 17'(ev.wait_ms);
            rtime_ff[uf]    <= '0;
            rgate_ff[uf]    <= ev.gate_ms;
            rstart_ff[uf]   <= rtarg_ff[uf];
            rtarg_ff[uf]    <= ev.level;
            idx_ff[pad_ff]  <= idx_ff[pad_ff] + 8'd1;
         end
         if (cmd.ramp_setup) begin
            cnt_ff <= '0;
            if (stat.div_needed) begin
               rtime_ff[ur] <= sum[15:0];
               down_ff <= rtarg_ff[ur] < rstart_ff[ur];
               base_ff <= rstart_ff[ur];
               den_ff  <= rgate_ff[ur];
               rem_ff  <= '0;
               quo_ff  <= '0;
               if (rtarg_ff[ur] >= rstart_ff[ur])
                  num_ff <= (rtarg_ff[ur] - rstart_ff[ur]) * sum[15:0];
               else
                  num_ff <= (rstart_ff[ur] - rtarg_ff[ur]) * sum[15:0]
                            + 32'(rgate_ff[ur]) - 32'd1;
            end else if (cmd.ramp_unit)
               hi_ff <= rtarg_ff[ur];
            else
               lo_ff <= rtarg_ff[ur];
         end
         if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 5'd1;
            num_ff <= {num_ff[30:0], 1'b0};
            if (rem_sh >= 17'(den_ff)) begin
               rem_ff <= rem_sh - 17'(den_ff);
               quo_ff <= {quo_ff[30:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[30:0], 1'b0};
            end
         end
         if (cmd.lvl_store) begin
            if (cmd.ramp_unit) hi_ff <= lvl_res;
            else lo_ff <= lvl_res;
         end
         if (cmd.emit) valid_ff <= 1'b1;
         else if (!rsp_stall) valid_ff <= 1'b0;
         if (cmd.emit) begin
            rsp_out_pad    <= pad_ff;
            rsp_low_level  <= lo_ff;
            rsp_high_level <= hi_ff;
         end
      end
   end

   assign rsp_valid = valid_ff;

endmodule

@@ sv/haptic_ramp_sequencer.sv @@
// Top level: haptic ramp sequencer, controller plus datapath.
// One item at a time; the input stays stalled until the current start or tick is done.
// A tick on an active pad fires its due events one by one and then, for each motor
// whose ramp is still running, runs a bit-serial 32-step divider shared by both motors.
// At most 5 events fire on one tick. The result sits in an output register
// and is held while rsp_stall is high. A new result waits in the last state until that
// register is free, and the input stays stalled meanwhile.
module haptic_ramp_sequencer #(
   parameter int PADS      = hrs_pkg::PadsDefault,
   parameter int EVENTS    = hrs_pkg::EventsDefault,
   parameter int SEQUENCES = hrs_pkg::SequencesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic        req_pad,
   input  logic [15:0] req_delta_ms,
   input  logic [2:0]  req_sequence_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_pad,
   output logic [15:0] rsp_low_level,
   output logic [15:0] rsp_high_level
);

   hrs_pkg::cmd_type  cmd;
   hrs_pkg::stat_type stat;

   hrs_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   hrs_dp #(.PADS(PADS), .EVENTS(EVENTS), .SEQUENCES(SEQUENCES)) u_dp (
      .clock, .reset, .req_opcode, .req_pad, .req_delta_ms, .req_sequence_req,
      .cmd, .stat, .rsp_stall, .rsp_valid, .rsp_out_pad, .rsp_low_level,
      .rsp_high_level
   );

endmodule

@@ sv/hrs_checker.sv @@
// Port-level checker for the haptic ramp sequencer, bound to the top level.
module hrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_low_level
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_low_level))
      else $error("result dropped or changed under stall");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted beat without going busy");

   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode && !rsp_valid |=> ##2 !rsp_valid)
      else $error("start produced a result");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind haptic_ramp_sequencer hrs_checker u_hrs_checker (
   .clock, .reset, .req_valid, .req_stall, .req_opcode, .rsp_valid, .rsp_stall,
   .rsp_low_level
);
